// ----- rtl/core/ncre_pkg.sv -----
// ----------------------------------------------------------------------------
// ncre_pkg
// Types, codes and constants shared by the neighbor RSSI table modules.
// ----------------------------------------------------------------------------
package ncre_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_QUERY = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HOP   = 2'd0,
    REG_FRESH = 2'd1,
    REG_SWEEP = 2'd2,
    REG_ALPHA = 2'd3
  } reg_t;

  // Register reset values
  localparam logic [31:0] HOP_RESET   = 32'd337254671;
  localparam logic [15:0] FRESH_RESET = 16'd120;
  localparam logic [15:0] SWEEP_RESET = 16'd30;
  localparam logic [6:0]  ALPHA_RESET = 7'd15;

  // Arithmetic constants
  localparam logic [6:0]         ALPHA_MAX  = 7'd100;
  localparam logic signed [7:0]  STALE_RSSI = -8'sd90;
  localparam logic signed [7:0]  MEAN_LOW   = -8'sd82;
  localparam logic signed [7:0]  MEAN_HIGH  = -8'sd62;
  localparam logic [9:0]         COST_LOW   = 10'd128;
  localparam logic [9:0]         COST_HIGH  = 10'd512;
  localparam logic [12:0]        DIV100_MUL = 13'd5243;  // ceil(2^19 / 100)
  localparam int                 DIV100_SH  = 19;
  localparam int                 MEAN_SH    = 20;
  localparam int                 HOP_SLOTS  = 4;

  // One neighbor record
  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] rx_time;
    logic [7:0]  chan;
  } ent_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_SR_RD, S_SR_CHK, S_MISS, S_INS, S_HIT,
    S_UPD_RD, S_UPD_MUL, S_UPD_WR, S_SUM_RD, S_SUM_ADD,
    S_MEAN, S_COST, S_RESP, S_TICK, S_SW_RD, S_SW_CHK, S_SW_WR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic ent_clr;
    logic ent_inc;
    logic ent_to_free;
    logic slot_clr;
    logic slot_inc;
    logic chk;
    logic set_full;
    logic ins_wr;
    logic ent_wr;
    logic mul;
    logic upd_wr;
    logic sum_add;
    logic mean;
    logic cost;
    logic load_rsp;
    logic tick;
    logic sw_wr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic last_ent;
    logic last_slot;
    logic match;
    logic free_ok;
    logic stale;
    logic sweep;
    logic out_busy;
  } sts_t;

  // Cost for a mean in [-82, -63], indexed by mean + 82: 512 - ceil(96d/5)
  function automatic logic [9:0] cost_lut(input logic [4:0] d);
    logic [9:0] c;
    case (d)
      5'd0:    c = 10'd512;
      5'd1:    c = 10'd492;
      5'd2:    c = 10'd473;
      5'd3:    c = 10'd454;
      5'd4:    c = 10'd435;
      5'd5:    c = 10'd416;
      5'd6:    c = 10'd396;
      5'd7:    c = 10'd377;
      5'd8:    c = 10'd358;
      5'd9:    c = 10'd339;
      5'd10:   c = 10'd320;
      5'd11:   c = 10'd300;
      5'd12:   c = 10'd281;
      5'd13:   c = 10'd262;
      5'd14:   c = 10'd243;
      5'd15:   c = 10'd224;
      5'd16:   c = 10'd204;
      5'd17:   c = 10'd185;
      5'd18:   c = 10'd166;
      5'd19:   c = 10'd147;
      default: c = COST_LOW;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/ncre_req_if.sv -----
// ----------------------------------------------------------------------------
// ncre_req_if
// Request channel: operation, neighbor address, sample and channel.
// ----------------------------------------------------------------------------
interface ncre_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [63:0]       link_addr;
  logic signed [7:0] rssi;
  logic [7:0]        channel;

  modport source (output valid, operation, link_addr, rssi, channel, input ready);
  modport sink   (input valid, operation, link_addr, rssi, channel, output ready);
endinterface

// ----- rtl/core/ncre_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ncre_rsp_if
// Response channel: lookup flags, mean RSSI, link cost and last channel.
// ----------------------------------------------------------------------------
interface ncre_rsp_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic              added;
  logic              table_full;
  logic signed [7:0] mean_rssi;
  logic [9:0]        rssi_cost;
  logic [7:0]        last_channel;

  modport source (output valid, found, added, table_full, mean_rssi, rssi_cost,
                  last_channel, input ready);
  modport sink   (input valid, found, added, table_full, mean_rssi, rssi_cost,
                  last_channel, output ready);
endinterface

// ----- rtl/core/ncre_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ncre_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ncre_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ncre_ctrl.sv -----
// ----------------------------------------------------------------------------
// ncre_ctrl
// Sequencer: walks the table for lookups and sweeps, steps channel slots.
// ----------------------------------------------------------------------------
module ncre_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ncre_pkg::sts_t  sts,
  output ncre_pkg::cmd_t  cmd
);

  ncre_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ncre_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ncre_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ncre_pkg::S_SR_RD;
        end
      end
      // dispatch happens once the request is latched
      ncre_pkg::S_SR_RD: begin
        case (sts.op)
          ncre_pkg::OP_RX, ncre_pkg::OP_QUERY: state_next = ncre_pkg::S_SR_CHK;
          ncre_pkg::OP_TICK:                   state_next = ncre_pkg::S_TICK;
          default:                             state_next = ncre_pkg::S_RESP;
        endcase
      end
      ncre_pkg::S_SR_CHK: begin
        cmd.chk = 1'b1;
        if (sts.match) begin
          state_next = ncre_pkg::S_HIT;
        end else if (sts.last_ent) begin
          state_next = ncre_pkg::S_MISS;
        end else begin
          cmd.ent_inc = 1'b1;
          state_next  = ncre_pkg::S_SR_RD;
        end
      end
      ncre_pkg::S_MISS: begin
        if (sts.op == ncre_pkg::OP_RX && sts.free_ok) begin
          cmd.ent_to_free = 1'b1;
          cmd.slot_clr    = 1'b1;
          state_next      = ncre_pkg::S_INS;
        end else begin
          cmd.set_full = (sts.op == ncre_pkg::OP_RX);
          state_next   = ncre_pkg::S_RESP;
        end
      end
      ncre_pkg::S_INS: begin
        cmd.ins_wr = 1'b1;
        if (sts.last_slot) begin
          cmd.ent_wr = 1'b1;
          state_next = ncre_pkg::S_MEAN;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      ncre_pkg::S_HIT: begin
        cmd.slot_clr = 1'b1;
        state_next   = (sts.op == ncre_pkg::OP_RX) ? ncre_pkg::S_UPD_RD
                                                   : ncre_pkg::S_SUM_RD;
      end
      ncre_pkg::S_UPD_RD:  state_next = ncre_pkg::S_UPD_MUL;
      ncre_pkg::S_UPD_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ncre_pkg::S_UPD_WR;
      end
      ncre_pkg::S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        if (sts.last_slot) begin
          cmd.ent_wr = 1'b1;
          state_next = ncre_pkg::S_MEAN;
        end else begin
          cmd.slot_inc = 1'b1;
          state_next   = ncre_pkg::S_UPD_RD;
        end
      end
      ncre_pkg::S_SUM_RD:  state_next = ncre_pkg::S_SUM_ADD;
      ncre_pkg::S_SUM_ADD: begin
        cmd.sum_add = 1'b1;
        if (sts.last_slot) begin
          state_next = ncre_pkg::S_MEAN;
        end else begin
          cmd.slot_inc = 1'b1;
          state_next   = ncre_pkg::S_SUM_RD;
        end
      end
      ncre_pkg::S_MEAN: begin
        cmd.mean   = 1'b1;
        state_next = ncre_pkg::S_COST;
      end
      ncre_pkg::S_COST: begin
        cmd.cost   = 1'b1;
        state_next = ncre_pkg::S_RESP;
      end
      ncre_pkg::S_RESP: begin
        if (!sts.out_busy) begin
          cmd.load_rsp = 1'b1;
          state_next   = ncre_pkg::S_IDLE;
        end
      end
      ncre_pkg::S_TICK: begin
        cmd.tick = 1'b1;
        if (sts.sweep) begin
          cmd.ent_clr = 1'b1;
          state_next  = ncre_pkg::S_SW_RD;
        end else begin
          state_next = ncre_pkg::S_RESP;
        end
      end
      ncre_pkg::S_SW_RD: state_next = ncre_pkg::S_SW_CHK;
      ncre_pkg::S_SW_CHK: begin
        if (sts.stale) begin
          cmd.slot_clr = 1'b1;
          state_next   = ncre_pkg::S_SW_WR;
        end else if (sts.last_ent) begin
          state_next = ncre_pkg::S_RESP;
        end else begin
          cmd.ent_inc = 1'b1;
          state_next  = ncre_pkg::S_SW_RD;
        end
      end
      ncre_pkg::S_SW_WR: begin
        cmd.sw_wr = 1'b1;
        if (!sts.last_slot) begin
          cmd.slot_inc = 1'b1;
        end else if (sts.last_ent) begin
          state_next = ncre_pkg::S_RESP;
        end else begin
          cmd.ent_inc = 1'b1;
          state_next  = ncre_pkg::S_SW_RD;
        end
      end
      default: state_next = ncre_pkg::S_IDLE;
    endcase
  end

  // Checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ncre_pkg::S_IDLE)
    else $error("ready outside idle");
  a_cap_next: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ncre_pkg::S_SR_RD)
    else $error("capture did not start lookup");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_rsp |=> state == ncre_pkg::S_IDLE)
    else $error("response load did not return to idle");

endmodule

// ----- rtl/core/ncre_dp.sv -----
// ----------------------------------------------------------------------------
// ncre_dp
// Datapath: neighbor and strength memories, EWMA, mean, cost, time and regs.
// ----------------------------------------------------------------------------
module ncre_dp #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int NUM_CHANNELS  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  ncre_pkg::cmd_t    cmd,
  output ncre_pkg::sts_t    sts,
  // request payload
  input  logic [1:0]        operation,
  input  logic [63:0]       link_addr,
  input  logic signed [7:0] rssi,
  input  logic [7:0]        channel,
  // response
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic              added,
  output logic              table_full,
  output logic signed [7:0] mean_rssi,
  output logic [9:0]        rssi_cost,
  output logic [7:0]        last_channel,
  // configuration
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int IDXW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int SLW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SDEP  = MAX_NEIGHBORS * NUM_CHANNELS;
  localparam int SAW   = (SDEP > 1) ? $clog2(SDEP) : 1;
  localparam int SUMW  = 9 + $clog2(NUM_CHANNELS);
  localparam int RECIP = ((1 << ncre_pkg::MEAN_SH) + NUM_CHANNELS - 1) / NUM_CHANNELS;
  localparam int MPW   = SUMW + ncre_pkg::MEAN_SH + 1;

  // Configuration registers
  logic [31:0] hop;
  logic [15:0] fresh_lim;
  logic [15:0] sweep_per;
  logic [6:0]  alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop       <= ncre_pkg::HOP_RESET;
      fresh_lim <= ncre_pkg::FRESH_RESET;
      sweep_per <= ncre_pkg::SWEEP_RESET;
      alpha     <= ncre_pkg::ALPHA_RESET;
    end else if (cfg_valid) begin
      case (ncre_pkg::reg_t'(cfg_index))
        ncre_pkg::REG_HOP:   hop       <= cfg_data;
        ncre_pkg::REG_FRESH: fresh_lim <= cfg_data[15:0];
        ncre_pkg::REG_SWEEP: sweep_per <= cfg_data[15:0];
        ncre_pkg::REG_ALPHA: alpha     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Latched request
  ncre_pkg::op_t     op_q;
  logic [63:0]       addr_q;
  logic signed [7:0] rssi_q;
  logic [7:0]        ch_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= ncre_pkg::op_t'(operation);
      addr_q <= link_addr;
      rssi_q <= rssi;
      ch_q   <= channel;
    end
  end

  // Entry and slot pointers
  logic [IDXW-1:0] ent_idx, free_idx;
  logic [SLW-1:0]  slot_idx;
  logic            free_ok, hit_q, added_q, full_q;
  logic [MAX_NEIGHBORS-1:0] valid;
  logic [SAW-1:0]  str_addr;
  logic            last_ent, last_slot;
  logic [31:0]     time_now;

  assign last_ent  = (ent_idx == IDXW'(MAX_NEIGHBORS - 1));
  assign last_slot = (slot_idx == SLW'(NUM_CHANNELS - 1));
  assign str_addr  = SAW'(SAW'(ent_idx) * SAW'(NUM_CHANNELS)) + SAW'(slot_idx);

  // Entry memory
  ncre_pkg::ent_t ent_mem [MAX_NEIGHBORS];
  ncre_pkg::ent_t ent_rd;

  always_ff @(posedge clk) begin
    if (cmd.ent_wr) ent_mem[ent_idx] <= '{addr: addr_q, rx_time: time_now, chan: ch_q};
    ent_rd <= ent_mem[ent_idx];
  end

  // Strength memory
  logic signed [7:0] str_mem [SDEP];
  logic signed [7:0] str_rd;
  logic signed [7:0] str_wdata;
  logic              str_we;

  always_ff @(posedge clk) begin
    if (str_we) str_mem[str_addr] <= str_wdata;
    str_rd <= str_mem[str_addr];
  end

  // Search status
  logic match;
  assign match = valid[ent_idx] && (ent_rd.addr == addr_q);

  // Time base and sweep counter
  logic [15:0] sweep_cnt, sweep_inc;
  logic        sweep_now, stale;

  assign sweep_inc = sweep_cnt + 16'd1;
  assign sweep_now = (sweep_inc >= sweep_per);
  assign stale     = valid[ent_idx] && ((time_now - ent_rd.rx_time) > {16'd0, fresh_lim});

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now  <= '0;
      sweep_cnt <= '0;
    end else if (cmd.tick) begin
      time_now  <= time_now + 32'd1;
      sweep_cnt <= sweep_now ? 16'd0 : sweep_inc;
    end
  end

  // EWMA: (old*(100-a) + sample*a) / 100, truncated toward zero
  logic [6:0]         a_sat, a_inv;
  logic signed [15:0] p_old, p_new, prod;
  logic [15:0]        pmag;
  logic [28:0]        qfull;
  logic [7:0]         q8;
  logic signed [7:0]  ewma_v;
  logic [2:0]         slot3;
  logic               slot_hit;

  assign a_sat = (alpha > ncre_pkg::ALPHA_MAX) ? ncre_pkg::ALPHA_MAX : alpha;
  assign a_inv = ncre_pkg::ALPHA_MAX - a_sat;
  assign p_old = 16'(str_rd) * 16'(signed'({1'b0, a_inv}));
  assign p_new = 16'(rssi_q) * 16'(signed'({1'b0, a_sat}));

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= p_old + p_new;
  end

  assign pmag   = prod[15] ? 16'(-prod) : 16'(prod);
  assign qfull  = 29'(pmag[13:0]) * 29'(ncre_pkg::DIV100_MUL);
  assign q8     = qfull[ncre_pkg::DIV100_SH +: 8];
  assign ewma_v = prod[15] ? signed'(8'(-q8)) : signed'(q8);

  // slot matches the receive channel only within the hop register
  assign slot3    = 3'(slot_idx);
  assign slot_hit = (slot3 < 3'(ncre_pkg::HOP_SLOTS)) &&
                    (hop[{slot3[1:0], 3'b000} +: 8] == ch_q);

  // Strength write port
  always_comb begin
    str_we    = 1'b0;
    str_wdata = rssi_q;
    if (cmd.ins_wr) begin
      str_we = 1'b1;
    end else if (cmd.upd_wr) begin
      str_we    = slot_hit;
      str_wdata = ewma_v;
    end else if (cmd.sw_wr) begin
      str_we    = 1'b1;
      str_wdata = ncre_pkg::STALE_RSSI;
    end
  end

  // Slot sum
  logic signed [SUMW-1:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.capture || cmd.slot_clr) acc <= '0;
    else if (cmd.ins_wr)             acc <= acc + SUMW'(rssi_q);
    else if (cmd.upd_wr)             acc <= acc + SUMW'(slot_hit ? ewma_v : str_rd);
    else if (cmd.sum_add)            acc <= acc + SUMW'(str_rd);
  end

  // Mean: sum / NUM_CHANNELS by reciprocal, truncated toward zero
  logic [SUMW-1:0]   amag;
  logic [MPW-1:0]    mprod;
  logic [7:0]        mq;
  logic signed [7:0] mean_q;
  logic [9:0]        cost_q;
  logic signed [7:0] mdiff;

  assign amag  = acc[SUMW-1] ? SUMW'(-acc) : SUMW'(acc);
  assign mprod = MPW'(amag) * MPW'(RECIP);
  assign mq    = mprod[ncre_pkg::MEAN_SH +: 8];
  assign mdiff = mean_q - ncre_pkg::MEAN_LOW;

  always_ff @(posedge clk) begin
    if (cmd.mean) mean_q <= acc[SUMW-1] ? signed'(8'(-mq)) : signed'(mq);
    if (cmd.cost) begin
      if (mean_q < ncre_pkg::MEAN_LOW)       cost_q <= ncre_pkg::COST_HIGH;
      else if (mean_q >= ncre_pkg::MEAN_HIGH) cost_q <= ncre_pkg::COST_LOW;
      else                                    cost_q <= ncre_pkg::cost_lut(mdiff[4:0]);
    end
  end

  // Pointers, flags and valid bits
  logic [7:0] lastch;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      ent_idx <= '0;
      hit_q   <= 1'b0;
      added_q <= 1'b0;
      full_q  <= 1'b0;
      free_ok <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ent_idx <= '0;
        hit_q   <= 1'b0;
        added_q <= 1'b0;
        full_q  <= 1'b0;
        free_ok <= 1'b0;
      end
      if (cmd.ent_clr) ent_idx <= '0;
      if (cmd.ent_inc) ent_idx <= ent_idx + IDXW'(1);
      if (cmd.chk) begin
        if (match) hit_q <= 1'b1;
        if (!valid[ent_idx] && !free_ok) begin
          free_ok  <= 1'b1;
          free_idx <= ent_idx;
        end
      end
      if (cmd.ent_to_free) begin
        ent_idx <= free_idx;
        added_q <= 1'b1;
      end
      if (cmd.set_full) full_q <= 1'b1;
      if (cmd.ent_wr) valid[ent_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture || cmd.slot_clr) slot_idx <= '0;
    else if (cmd.slot_inc)           slot_idx <= slot_idx + SLW'(1);
    if (cmd.chk && match) lastch <= ent_rd.chan;
    else if (cmd.ent_wr)  lastch <= ch_q;
  end

  // Response register
  logic rep;
  assign rep = hit_q | added_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_rsp) begin
      found        <= hit_q;
      added        <= added_q;
      table_full   <= full_q;
      mean_rssi    <= rep ? mean_q : 8'sd0;
      rssi_cost    <= rep ? cost_q : 10'd0;
      last_channel <= rep ? lastch : 8'd0;
    end
  end

  // Status
  assign sts.op        = op_q;
  assign sts.last_ent  = last_ent;
  assign sts.last_slot = last_slot;
  assign sts.match     = match;
  assign sts.free_ok   = free_ok;
  assign sts.stale     = stale;
  assign sts.sweep     = sweep_now;
  assign sts.out_busy  = out_valid && !out_ready;

  // Checks
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && added) && !(table_full && (found || added)))
    else $error("conflicting lookup flags");
  a_cost_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (found || added) |-> rssi_cost >= ncre_pkg::COST_LOW &&
                                      rssi_cost <= ncre_pkg::COST_HIGH)
    else $error("cost out of range");
  a_valid_set: assert property (@(posedge clk) disable iff (rst)
    cmd.ent_wr |=> valid[$past(ent_idx)])
    else $error("written entry not valid");
  a_full_none: assert property (@(posedge clk) disable iff (rst)
    cmd.set_full |-> !free_ok)
    else $error("drop with a free entry");

endmodule

// ----- rtl/core/neighbor_channel_rssi_ewma_table.sv -----
// ----------------------------------------------------------------------------
// neighbor_channel_rssi_ewma_table
// Per-neighbor RSSI table with per-channel EWMA, staleness sweep and cost.
// ----------------------------------------------------------------------------
// One request is handled at a time. A receive or query scans the table
// entry by entry until the address matches and branches on the hit or
// miss. It then inserts a new neighbor slot by slot, blends a known
// neighbor slot by slot (read, multiply, write) or sums the slots for a
// query, then computes mean and cost before the response; a miss with no
// insertion goes straight to the response. A tick advances the time base,
// and a sweep tick also scans every entry and rewrites each stale entry's
// slots; the scan reads the single-port neighbor memory one entry at a time.
// The response sits in an output register, so a slow consumer only stalls
// the next response load. Configuration writes are always accepted and must
// be made while no request is in flight. No clearing pass follows reset.
module neighbor_channel_rssi_ewma_table #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int NUM_CHANNELS  = 4
) (
  input logic       clk,
  input logic       rst,
  ncre_req_if.sink  req,
  ncre_rsp_if.source rsp,
  ncre_cfg_if.sink  cfg
);

  ncre_pkg::cmd_t cmd;
  ncre_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  ncre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ncre_dp #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .NUM_CHANNELS  (NUM_CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (req.operation),
    .link_addr    (req.link_addr),
    .rssi         (req.rssi),
    .channel      (req.channel),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .found        (rsp.found),
    .added        (rsp.added),
    .table_full   (rsp.table_full),
    .mean_rssi    (rsp.mean_rssi),
    .rssi_cost    (rsp.rssi_cost),
    .last_channel (rsp.last_channel),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the neighbor RSSI table. A behavioral predictor
// tracks the table, time and registers; every response is matched against it.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic              found;
    logic              added;
    logic              table_full;
    logic signed [7:0] mean_rssi;
    logic [9:0]        rssi_cost;
    logic [7:0]        last_channel;
  } link_report_t;

  localparam int NBR = 16;
  localparam int CHN = 4;

  logic clk;
  logic rst;

  ncre_req_if req ();
  ncre_rsp_if rsp ();
  ncre_cfg_if cfg ();

  neighbor_channel_rssi_ewma_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Predicted table contents and registers
  logic [31:0]       hop_seq;
  logic [15:0]       fresh_lim;
  logic [15:0]       sweep_per;
  logic [6:0]        alpha_pct;
  logic              nbr_valid [NBR];
  logic [63:0]       nbr_addr [NBR];
  logic [31:0]       nbr_rx_time [NBR];
  logic [7:0]        nbr_chan [NBR];
  logic signed [7:0] nbr_rssi [NBR][CHN];
  logic [31:0]       now_ticks;
  logic [15:0]       sweep_cnt;

  link_report_t pending_reports[$];
  logic [63:0]  known_addrs[$];
  int           errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           accepted_reqs;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cost mapping of a mean value
  function automatic logic [9:0] link_cost(int m);
    if (m < -82) return 10'd512;
    if (m < -62) return 10'(512 - (96 * (m + 82) + 4) / 5);
    return 10'd128;
  endfunction

  function automatic int lookup(logic [63:0] a);
    for (int i = 0; i < NBR; i++)
      if (nbr_valid[i] && nbr_addr[i] == a) return i;
    return -1;
  endfunction

  // Fill mean, cost and channel of an entry
  function automatic link_report_t fill_entry(link_report_t r, int e);
    int sum;
    sum = 0;
    for (int s = 0; s < CHN; s++) sum += int'(nbr_rssi[e][s]);
    sum = sum / CHN;
    r.mean_rssi    = 8'(sum);
    r.rssi_cost    = link_cost(sum);
    r.last_channel = nbr_chan[e];
    return r;
  endfunction

  // Apply one request to the predicted table and return its response
  function automatic link_report_t table_update(ncre_pkg::op_t op, logic [63:0] a,
                                                logic signed [7:0] smp,
                                                logic [7:0] ch);
    link_report_t r;
    int e;
    int al;
    int v;
    r = '0;
    case (op)
      ncre_pkg::OP_RX: begin
        e = lookup(a);
        if (e < 0) begin
          for (e = 0; e < NBR; e++)
            if (!nbr_valid[e]) break;
          if (e >= NBR) begin
            r.table_full = 1'b1;
            return r;
          end
          nbr_valid[e] = 1'b1;
          nbr_addr[e]  = a;
          for (int s = 0; s < CHN; s++) nbr_rssi[e][s] = smp;
          r.added = 1'b1;
        end else begin
          al = (alpha_pct > 100) ? 100 : int'(alpha_pct);
          for (int s = 0; s < CHN; s++)
            if (hop_seq[8*s +: 8] == ch) begin
              v = (int'(nbr_rssi[e][s]) * (100 - al) + int'(smp) * al) / 100;
              nbr_rssi[e][s] = 8'(v);
            end
          r.found = 1'b1;
        end
        nbr_rx_time[e] = now_ticks;
        nbr_chan[e]    = ch;
        r = fill_entry(r, e);
      end
      ncre_pkg::OP_QUERY: begin
        e = lookup(a);
        if (e >= 0) begin
          r.found = 1'b1;
          r = fill_entry(r, e);
        end
      end
      ncre_pkg::OP_TICK: begin
        now_ticks = now_ticks + 1;
        sweep_cnt = sweep_cnt + 1;
        if (sweep_cnt >= sweep_per) begin
          sweep_cnt = '0;
          for (int i = 0; i < NBR; i++)
            if (nbr_valid[i] && (now_ticks - nbr_rx_time[i]) > 32'(fresh_lim))
              for (int s = 0; s < CHN; s++) nbr_rssi[i][s] = ncre_pkg::STALE_RSSI;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one request; valid stays high until the next call or the end
  task automatic send_req(ncre_pkg::op_t op, logic [63:0] a, logic signed [7:0] smp,
                          logic [7:0] ch);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
      @(negedge clk);
    end
    req.valid     = 1'b1;
    req.operation = op;
    req.link_addr = a;
    req.rssi      = smp;
    req.channel   = ch;
    do @(posedge clk); while (!req.ready);
    pending_reports.push_back(table_update(op, a, smp, ch));
    accepted_reqs++;
  endtask

  // Drop valid and wait until every response is back
  task automatic drain();
    @(negedge clk);
    req.valid = 1'b0;
    wait (pending_reports.size() == 0);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(ncre_pkg::reg_t idx, logic [31:0] d);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = d;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      ncre_pkg::REG_HOP:   hop_seq   = d;
      ncre_pkg::REG_FRESH: fresh_lim = d[15:0];
      ncre_pkg::REG_SWEEP: sweep_per = d[15:0];
      ncre_pkg::REG_ALPHA: alpha_pct = d[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Receive with a new address, remembered for later hits
  task automatic rx_new(logic [63:0] a, logic signed [7:0] smp, logic [7:0] ch);
    known_addrs.push_back(a);
    send_req(ncre_pkg::OP_RX, a, smp, ch);
  endtask

  // Receiver ready pattern
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Response checker
  always @(posedge clk) begin
    link_report_t got;
    link_report_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.found, rsp.added, rsp.table_full, rsp.mean_rssi, rsp.rssi_cost,
             rsp.last_channel};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected response %p", $time, got);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Field extremes, every operation, EWMA corners
  task automatic test_basic_ops();
    rx_new(64'h0, -8'sd128, hop_seq[7:0]);
    rx_new('1, 8'sd127, hop_seq[31:24]);
    send_req(ncre_pkg::OP_RX, 64'h0, 8'sd127, hop_seq[7:0]);
    send_req(ncre_pkg::OP_RX, '1, -8'sd128, 8'hFF);
    send_req(ncre_pkg::OP_QUERY, '1, 8'sd0, 8'd0);
    send_req(ncre_pkg::OP_QUERY, 64'h5555_AAAA_5555_AAAA, 8'sd0, 8'd0);
    send_req(ncre_pkg::OP_NONE, '1, -8'sd1, 8'hFF);
    send_req(ncre_pkg::OP_TICK, 64'h0, 8'sd0, 8'd0);
    drain();
    // alpha above range, then zero alpha and full alpha, with duplicated hop channels
    write_reg(ncre_pkg::REG_HOP, 32'h0B0B_0B0B);
    write_reg(ncre_pkg::REG_ALPHA, 32'd127);
    send_req(ncre_pkg::OP_RX, 64'h0, -8'sd7, 8'h0B);
    drain();
    write_reg(ncre_pkg::REG_ALPHA, 32'd0);
    send_req(ncre_pkg::OP_RX, '1, -8'sd100, 8'h0B);
    drain();
    write_reg(ncre_pkg::REG_ALPHA, 32'd100);
    send_req(ncre_pkg::OP_RX, '1, -8'sd3, 8'h0B);
    send_req(ncre_pkg::OP_QUERY, 64'h0, 8'sd0, 8'd0);
    drain();
  endtask

  // Stale entries forced to the sweep value; zero sweep period
  task automatic test_staleness();
    write_reg(ncre_pkg::REG_FRESH, 32'd1);
    write_reg(ncre_pkg::REG_SWEEP, 32'd0);
    rx_new(64'h0123_4567_89AB_CDEF, 8'sd20, 8'h0B);
    repeat (3) send_req(ncre_pkg::OP_TICK, 64'h0, 8'sd0, 8'd0);
    send_req(ncre_pkg::OP_QUERY, 64'h0123_4567_89AB_CDEF, 8'sd0, 8'd0);
    drain();
    write_reg(ncre_pkg::REG_FRESH, 32'd65535);
    write_reg(ncre_pkg::REG_SWEEP, 32'd65535);
    drain();
  endtask

  // Fill the table across the cost ramp, then overflow it
  task automatic test_table_full();
    for (int i = 0; i < 16; i++)
      rx_new({$urandom, $urandom}, 8'(-90 + 2 * i), 8'h0B);
    drain();
  endtask

  // Random traffic over known and new neighbors
  task automatic test_random(int n);
    int k;
    logic [63:0] a;
    logic [7:0] ch;
    ncre_pkg::op_t op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      op = (k < 45) ? ncre_pkg::OP_RX : (k < 70) ? ncre_pkg::OP_QUERY :
           (k < 95) ? ncre_pkg::OP_TICK : ncre_pkg::OP_NONE;
      a = ($urandom_range(9) < 8 && known_addrs.size() > 0)
          ? known_addrs[$urandom_range(known_addrs.size() - 1)] : {$urandom, $urandom};
      ch = ($urandom_range(3) != 0) ? hop_seq[8*$urandom_range(3) +: 8] : 8'($urandom);
      send_req(op, a, 8'($urandom), ch);
    end
    drain();
  endtask

  task automatic random_regs();
    write_reg(ncre_pkg::REG_HOP, $urandom);
    write_reg(ncre_pkg::REG_FRESH, $urandom_range(1, 40));
    write_reg(ncre_pkg::REG_SWEEP, $urandom_range(0, 8));
    write_reg(ncre_pkg::REG_ALPHA, $urandom_range(0, 127));
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.operation = ncre_pkg::OP_NONE;
    req.link_addr = '0;
    req.rssi = '0;
    req.channel = '0;
    cfg.valid = 1'b0;
    cfg.index = ncre_pkg::REG_HOP;
    cfg.data = '0;
    rsp.ready = 1'b0;
    errors = 0;
    accepted_reqs = 0;
    send_idle_pct = 17;
    recv_idle_pct = 51;
    hop_seq = ncre_pkg::HOP_RESET;
    fresh_lim = ncre_pkg::FRESH_RESET;
    sweep_per = ncre_pkg::SWEEP_RESET;
    alpha_pct = ncre_pkg::ALPHA_RESET;
    now_ticks = '0;
    sweep_cnt = '0;
    for (int i = 0; i < NBR; i++) nbr_valid[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    test_staleness();
    test_table_full();
    random_regs();
    test_random(230);
    send_idle_pct = 51;
    recv_idle_pct = 17;
    random_regs();
    test_random(230);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_regs();
    test_random(230);

    $display("Ran %0d requests: receive, query, tick and idle codes; insertion,", accepted_reqs);
    $display("full table, EWMA blending, staleness sweeps and several register settings.");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ncre_pkg.sv
rtl/core/ncre_req_if.sv
rtl/core/ncre_rsp_if.sv
rtl/core/ncre_cfg_if.sv
rtl/core/ncre_ctrl.sv
rtl/core/ncre_dp.sv
rtl/core/neighbor_channel_rssi_ewma_table.sv
tb/sv/testbench.sv
